// ----- src/ptrl_pkg.sv -----
// Shared types, constants and codes of the priority token rate limiter.
package ptrl_pkg;

  localparam int unsigned QueueDepth = 8;
  localparam int unsigned NumQueues  = 4;
  localparam int unsigned MaxOut     = 32;
  localparam int unsigned QW         = $clog2(QueueDepth);
  localparam int unsigned CW         = $clog2(QueueDepth + 1);
  localparam int unsigned AW         = $clog2(NumQueues * QueueDepth);
  localparam int unsigned NW         = $clog2(MaxOut + 1);
  localparam int unsigned CmdFifoDepth = 2;

  localparam logic [19:0] UsPerSec = 20'd1000000;

  localparam logic [19:0] RstTokensPerSec = 20'd1000;
  localparam logic [19:0] RstCompWait     = 20'(700 * 1000);
  localparam logic [19:0] RstPfStartWait  = 20'(900 * 1000);
  localparam logic [19:0] RstPfMaxWait    = 20'(900 * 1000);
  localparam logic [19:0] RstPfStep       = 20'(50 * 1000);

  localparam logic [2:0] CfgTokensPerSec = 3'd0;
  localparam logic [2:0] CfgCompWait     = 3'd1;
  localparam logic [2:0] CfgPfStartWait  = 3'd2;
  localparam logic [2:0] CfgPfMaxWait    = 3'd3;
  localparam logic [2:0] CfgPfStep       = 3'd4;

  localparam logic [1:0] OpRequest  = 2'd0;
  localparam logic [1:0] OpTick     = 2'd1;
  localparam logic [1:0] OpShutdown = 2'd2;
  localparam logic [1:0] OpUnused   = 2'd3;

  localparam logic [2:0] KindGranted  = 3'd0;
  localparam logic [2:0] KindQueued   = 3'd1;
  localparam logic [2:0] KindRejected = 3'd2;
  localparam logic [2:0] KindFromQ    = 3'd3;
  localparam logic [2:0] KindReleased = 3'd4;

  localparam logic [2:0] SrcBypass = 3'd4;

  typedef enum logic [1:0] {
    CMD_REQ,
    CMD_TICK,
    CMD_STOP,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  source;
    logic [7:0]  tag;
    logic [15:0] advance_us;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  grant_source;
    logic [7:0]  grant_tag;
    logic [19:0] tokens_left;
    logic        last;
  } out_res_t;

  typedef struct packed {
    cmd_e        cmd;
    logic        bypass;
    logic [1:0]  qidx;
    logic [2:0]  source;
    logic [7:0]  tag;
    logic [15:0] advance_us;
  } cmd_t;

  typedef struct packed {
    logic we;
    logic [2:0] idx;
    logic [19:0] wdata;
  } cfg_t;

endpackage

// ----- src/priority_token_rate_limiter_core.sv -----
// Top level of the priority token rate limiter.
// Requests enter on the in channel (valid/ready) as opcode, source, tag and
// advance_us. Opcode request asks for a token, tick advances time and
// dispatches waiters, shutdown releases all waiters.
// Each request produces one result; a tick or shutdown produces zero to 32
// results on the out channel (valid/ready), the final one flagged by last.
// A two-entry command queue separates decoding from execution, so the input
// is accepted while results are still being delivered.
// A bypass request, or any request after shutdown, is granted without the
// token bucket; other token requests pass through the refill step first.
// Each grant or release from a wait queue goes through the registered read of
// the tag memory, and empty queues are passed over one by one.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once.
// The user makes them while the block is idle; the block does not enforce it.
// Reset loads the register defaults, a full bucket and empty queues; no
// clearing pass is needed. When the receiver stalls, results hold in the
// output and staging registers and execution waits.
module priority_token_rate_limiter_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ptrl_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ptrl_pkg::out_res_t out_res_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [19:0]        cfg_wdata_i
);
  import ptrl_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_take;
  cfg_t cfg;

  assign cfg = '{cfg_we_i, cfg_idx_i, cfg_wdata_i};

  ptrl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_take_i  (cmd_take),
    .cmd_o       (cmd)
  );

  ptrl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_take_o  (cmd_take),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule

// ----- src/ptrl_front.sv -----
// Front end: accepts requests, decodes them and queues them for the back end.
module ptrl_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ptrl_pkg::in_req_t in_req_i,
  output logic             cmd_valid_o,
  input  logic             cmd_take_i,
  output ptrl_pkg::cmd_t   cmd_o
);
  import ptrl_pkg::*;

  localparam int unsigned PW = $clog2(CmdFifoDepth);

  cmd_t             fifo_q [CmdFifoDepth];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]      cnt_q, cnt_d;
  cmd_t             dec;
  logic             push, pop;

  always_comb begin
    dec = '0;
    unique case (in_req_i.opcode)
      OpRequest:  dec.cmd = CMD_REQ;
      OpTick:     dec.cmd = CMD_TICK;
      OpShutdown: dec.cmd = CMD_STOP;
      default:    dec.cmd = CMD_NOP;
    endcase
    dec.bypass     = in_req_i.source >= SrcBypass;
    dec.qidx       = in_req_i.source[1:0];
    dec.source     = in_req_i.source;
    dec.tag        = in_req_i.tag;
    dec.advance_us = in_req_i.advance_us;
  end

  assign in_ready_o  = cnt_q != (PW + 1)'(CmdFifoDepth);
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = fifo_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_take_i && cmd_valid_o;

  always_comb begin
    wr_d  = push ? ((wr_q == PW'(CmdFifoDepth - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop ? ((rd_q == PW'(CmdFifoDepth - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PW + 1)'(push) - (PW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= dec;
    end
  end

endmodule

// ----- src/ptrl_back.sv -----
// Back end: token bucket state, per-source wait queues and result sequencing.
module ptrl_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptrl_pkg::cfg_t    cfg_i,
  input  logic              cmd_valid_i,
  output logic              cmd_take_o,
  input  ptrl_pkg::cmd_t    cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ptrl_pkg::out_res_t out_res_o
);
  import ptrl_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_START  = 10'b0000000010,
    S_TIME   = 10'b0000000100,
    S_REFILL = 10'b0000001000,
    S_REQ    = 10'b0000010000,
    S_DISP   = 10'b0000100000,
    S_DRD    = 10'b0001000000,
    S_REL    = 10'b0010000000,
    S_RRD    = 10'b0100000000,
    S_FIN    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  cmd_t   cur_q, cur_d;

  logic [19:0] tps_q, comp_q, pfmax_q, pfstep_q;
  logic [19:0] micros_q, micros_d;
  logic [31:0] sec_q, sec_d, nrs_q, nrs_d;
  logic [19:0] tok_q, tok_d, pw_q, pw_d;
  logic        stop_q, stop_d;
  logic [QW-1:0] head_q [NumQueues];
  logic [QW-1:0] head_d [NumQueues];
  logic [CW-1:0] cnt_q [NumQueues];
  logic [CW-1:0] cnt_d [NumQueues];
  logic [1:0]  q_q, q_d;
  logic [NW-1:0] n_q, n_d;

  logic [7:0]  mem [NumQueues * QueueDepth];
  logic [7:0]  rd_data_q;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;

  out_res_t stg_q, stg_d, out_q, out_d;
  logic     stg_valid_q, stg_valid_d, out_valid_q, out_valid_d;
  logic     can_push, ok_emit, emit, fin_push;
  out_res_t emit_res;

  logic [20:0] adv_sum;
  logic [20:0] pw_up;
  logic [19:0] pw_dn, pw_new;
  logic [19:0] thr;
  logic [CW:0] slot_sum;
  logic [QW-1:0] slot;
  logic        any_cnt;

  assign can_push    = !out_valid_q || out_ready_i;
  assign ok_emit     = !stg_valid_q || can_push;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_comb begin
    unique case (q_q)
      2'd0:    thr = pw_q;
      2'd1:    thr = comp_q;
      default: thr = '0;
    endcase
  end

  assign adv_sum  = {1'b0, micros_q} + 21'(cur_q.advance_us);
  assign any_cnt  = (cnt_q[0] != '0) || (cnt_q[1] != '0) || (cnt_q[2] != '0) ||
                    (cnt_q[3] != '0);
  assign slot_sum = (CW + 1)'(head_q[cur_q.qidx]) + (CW + 1)'(cnt_q[cur_q.qidx]);
  assign slot     = (slot_sum >= (CW + 1)'(QueueDepth)) ?
                    QW'(slot_sum - (CW + 1)'(QueueDepth)) : QW'(slot_sum);
  assign pw_up    = {1'b0, pw_q} + {1'b0, pfstep_q};

  always_comb begin
    pw_dn = (pw_q > pfstep_q) ? pw_q - pfstep_q : '0;
    if (tok_q != '0) begin
      pw_new = (pw_dn < comp_q) ? comp_q : pw_dn;
    end else begin
      pw_new = (pw_up > {1'b0, pfmax_q}) ? pfmax_q : pw_up[19:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    micros_d   = micros_q;
    sec_d      = sec_q;
    nrs_d      = nrs_q;
    tok_d      = tok_q;
    pw_d       = pw_q;
    stop_d     = stop_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    q_d        = q_q;
    n_d        = n_q;
    cmd_take_o = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = AW'(32'(cur_q.qidx) * QueueDepth + 32'(slot));
    mem_raddr  = AW'(32'(q_q) * QueueDepth + 32'(head_q[q_q]));
    emit       = 1'b0;
    emit_res   = '0;
    fin_push   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        n_d = '0;
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          cur_d      = cmd_i;
          state_d    = S_START;
        end
      end
      S_START: begin
        unique case (cur_q.cmd)
          CMD_REQ: begin
            if (stop_q || cur_q.bypass) begin
              if (ok_emit) begin
                emit     = 1'b1;
                emit_res = '{KindGranted, cur_q.source, cur_q.tag, tok_q, 1'b0};
                state_d  = S_FIN;
              end
            end else begin
              state_d = S_REFILL;
            end
          end
          CMD_TICK: state_d = S_TIME;
          CMD_STOP: begin
            stop_d  = 1'b1;
            q_d     = 2'd3;
            state_d = S_REL;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_TIME: begin
        if (adv_sum >= {1'b0, UsPerSec}) begin
          micros_d = 20'(adv_sum - {1'b0, UsPerSec});
          sec_d    = sec_q + 32'd1;
        end else begin
          micros_d = adv_sum[19:0];
        end
        q_d = 2'd3;
        priority if (stop_q) state_d = S_REL;
        else if (any_cnt)    state_d = S_REFILL;
        else                 state_d = S_FIN;
      end
      S_REFILL: begin
        if (sec_q >= nrs_q) begin
          pw_d  = pw_new;
          tok_d = tps_q;
          nrs_d = sec_q + 32'd1;
        end
        q_d     = 2'd3;
        state_d = (cur_q.cmd == CMD_REQ) ? S_REQ : S_DISP;
      end
      S_REQ: begin
        q_d = cur_q.qidx;
        if (ok_emit) begin
          emit    = 1'b1;
          state_d = S_FIN;
          priority if (tok_q != '0 && micros_q >= thr && cnt_q[cur_q.qidx] == '0
                       && q_q == cur_q.qidx) begin
            tok_d    = tok_q - 20'd1;
            emit_res = '{KindGranted, cur_q.source, cur_q.tag, tok_q - 20'd1, 1'b0};
          end else if (q_q != cur_q.qidx) begin
            emit    = 1'b0;
            state_d = S_REQ;
          end else if (cnt_q[cur_q.qidx] >= CW'(QueueDepth)) begin
            emit_res = '{KindRejected, cur_q.source, cur_q.tag, tok_q, 1'b0};
          end else begin
            mem_we                = 1'b1;
            cnt_d[cur_q.qidx]     = cnt_q[cur_q.qidx] + 1'b1;
            emit_res = '{KindQueued, cur_q.source, cur_q.tag, tok_q, 1'b0};
          end
        end
      end
      S_DISP: begin
        priority if (tok_q == '0 || micros_q < thr || n_q == NW'(MaxOut)) begin
          state_d = S_FIN;
        end else if (cnt_q[q_q] == '0) begin
          if (q_q == 2'd0) state_d = S_FIN;
          else             q_d     = q_q - 2'd1;
        end else begin
          mem_re  = 1'b1;
          state_d = S_DRD;
        end
      end
      S_REL: begin
        priority if (n_q == NW'(MaxOut)) begin
          state_d = S_FIN;
        end else if (cnt_q[q_q] == '0) begin
          if (q_q == 2'd0) state_d = S_FIN;
          else             q_d     = q_q - 2'd1;
        end else begin
          mem_re  = 1'b1;
          state_d = S_RRD;
        end
      end
      S_DRD, S_RRD: begin
        if (ok_emit) begin
          emit         = 1'b1;
          head_d[q_q]  = (head_q[q_q] == QW'(QueueDepth - 1)) ? '0 : head_q[q_q] + 1'b1;
          cnt_d[q_q]   = cnt_q[q_q] - 1'b1;
          n_d          = n_q + 1'b1;
          if (state_q == S_DRD) begin
            tok_d    = tok_q - 20'd1;
            emit_res = '{KindFromQ, {1'b0, q_q}, rd_data_q, tok_q - 20'd1, 1'b0};
            state_d  = S_DISP;
          end else begin
            emit_res = '{KindReleased, {1'b0, q_q}, rd_data_q, tok_q, 1'b0};
            state_d  = S_REL;
          end
        end
      end
      S_FIN: begin
        if (!stg_valid_q) begin
          state_d = S_IDLE;
        end else if (can_push) begin
          fin_push = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_i.we) begin
      if (cfg_i.idx == CfgTokensPerSec) begin
        tok_d = cfg_i.wdata;
      end else if (cfg_i.idx == CfgPfStartWait) begin
        pw_d = cfg_i.wdata;
      end
    end
  end

  always_comb begin
    stg_d       = stg_q;
    stg_valid_d = stg_valid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (emit) begin
      if (stg_valid_q) begin
        out_d       = stg_q;
        out_valid_d = 1'b1;
      end
      stg_d       = emit_res;
      stg_valid_d = 1'b1;
    end else if (fin_push) begin
      out_d       = stg_q;
      out_d.last  = 1'b1;
      out_valid_d = 1'b1;
      stg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tps_q       <= RstTokensPerSec;
      comp_q      <= RstCompWait;
      pfmax_q     <= RstPfMaxWait;
      pfstep_q    <= RstPfStep;
      micros_q    <= '0;
      sec_q       <= '0;
      nrs_q       <= 32'd1;
      tok_q       <= RstTokensPerSec;
      pw_q        <= RstPfStartWait;
      stop_q      <= 1'b0;
      head_q      <= '{default: '0};
      cnt_q       <= '{default: '0};
      q_q         <= '0;
      n_q         <= '0;
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      micros_q    <= micros_d;
      sec_q       <= sec_d;
      nrs_q       <= nrs_d;
      tok_q       <= tok_d;
      pw_q        <= pw_d;
      stop_q      <= stop_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      q_q         <= q_d;
      n_q         <= n_d;
      stg_valid_q <= stg_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.we) begin
        unique case (cfg_i.idx)
          CfgTokensPerSec: tps_q    <= cfg_i.wdata;
          CfgCompWait:     comp_q   <= cfg_i.wdata;
          CfgPfMaxWait:    pfmax_q  <= cfg_i.wdata;
          CfgPfStep:       pfstep_q <= cfg_i.wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    stg_q <= stg_d;
    out_q <= out_d;
    if (mem_we) begin
      mem[mem_waddr] <= cur_q.tag;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

endmodule
